FILE: sv/pknn_pkg.sv
// ----------------------------------------------------------------------------
// pknn_pkg
// Shared constants and codes for the point list with k-nearest query.
// ----------------------------------------------------------------------------
package pknn_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int MAX_K_DEF    = 64;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BAD   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

FILE: sv/point_list_k_nearest.sv
// ----------------------------------------------------------------------------
// point_list_k_nearest
// Ordered list of 2D points in one memory, with insert/remove shifting and a
// k-nearest query by repeated scans.
// ----------------------------------------------------------------------------
// Operation: append/insert and remove shift the entries from the given
//   position on by one place (one memory entry moved per cycle); a query
//   makes one full memory scan per reported point and emits one beat per
//   result, held while out_stall is high.
// Throughput: one item at a time; the next is taken once all beats are out.
// Reset: rst_n (sync, active low) clears the count and control; the point
//   memory is not cleared, only entries below the count are ever used.
module point_list_k_nearest
  import pknn_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int MAX_K    = MAX_K_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic [9:0]         in_position,
  input  logic [6:0]         in_k_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [32:0]        out_dist_sq,
  output logic [10:0]        out_count_now,
  output logic               out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(MAX_K + 1);
  localparam int EW = CW + 10;
  localparam int EK = CW + 7;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic          ins_r;
  logic [31:0]   pt_r;
  logic [CW-1:0] posc_r, sh_r;
  logic          pv_r;
  logic [AW-1:0] pwa_r;

  logic [KW-1:0] k_r, r_r;
  logic [CW-1:0] rd_i_r;
  logic          v0_r, v1_r;
  logic [AW-1:0] idx0_r, idx1_r;
  logic [31:0]   pt1_r;
  logic [31:0]   sqx_r, sqy_r;
  logic          found_r;
  logic [32:0]   best_d_r, prev_d_r;
  logic [AW-1:0] best_i_r, prev_i_r;
  logic [31:0]   best_pt_r;

  logic [1:0]    st_r;
  logic [31:0]   opt_r;
  logic [32:0]   od_r;
  logic          last_r;

  // memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[ra];
  end

  logic [EW-1:0] pos_w, cnt_w;
  logic [EK-1:0] k_w, cntk_w, kmin_w;
  logic          more;
  logic          full;
  logic [CW+10:0] cnt_out;

  assign pos_w   = {{CW{1'b0}}, in_position};
  assign cnt_w   = {{10{1'b0}}, count_r};
  assign k_w     = {{CW{1'b0}}, in_k_count};
  assign cntk_w  = {{7{1'b0}}, count_r};
  assign full    = (count_r >= CW'(CAPACITY));
  assign cnt_out = {11'b0, count_r};

  always_comb begin
    kmin_w = (k_w < cntk_w) ? k_w : cntk_w;
    if (kmin_w > EK'(MAX_K)) kmin_w = EK'(MAX_K);
  end

  assign more = ins_r ? (sh_r > posc_r) : (sh_r < count_r);

  // stage 1: squared components
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  assign dx  = {rdata_r[15], rdata_r[15:0]} - {pt_r[15], pt_r[15:0]};
  assign dy  = {rdata_r[31], rdata_r[31:16]} - {pt_r[31], pt_r[31:16]};
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);

  // stage 2: distance and selection
  logic [32:0] d2;
  logic        skip;
  assign d2   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign skip = (r_r != '0) &&
                ((d2 < prev_d_r) || ((d2 == prev_d_r) && (idx1_r <= prev_i_r)));

  always_comb begin
    we = 1'b0;
    wa = pwa_r;
    wd = rdata_r;
    ra = rd_i_r[AW-1:0];
    unique case (state_r)
      S_SHIFT: begin
        ra = ins_r ? AW'(sh_r - 1'b1) : sh_r[AW-1:0];
        if (pv_r) begin
          we = 1'b1;
        end else if (!more && ins_r) begin
          we = 1'b1;
          wa = posc_r[AW-1:0];
          wd = pt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pv_r    <= 1'b0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pt_r  <= {in_y, in_x};
            ins_r <= (in_op != OP_REMOVE);
            pv_r  <= 1'b0;
            opt_r <= '0;
            od_r  <= '0;
            last_r <= 1'b1;
            unique case (op_t'(in_op))
              OP_APPEND, OP_INSERT: begin
                if (full) begin
                  st_r <= ST_FULL; state_r <= S_EMIT;
                end else if (in_op == OP_INSERT && pos_w > cnt_w) begin
                  st_r <= ST_BAD; state_r <= S_EMIT;
                end else begin
                  sh_r    <= count_r;
                  posc_r  <= (in_op == OP_APPEND) ? count_r : pos_w[CW-1:0];
                  state_r <= S_SHIFT;
                end
              end
              OP_REMOVE: begin
                if (pos_w >= cnt_w) begin
                  st_r <= ST_BAD; state_r <= S_EMIT;
                end else begin
                  posc_r  <= pos_w[CW-1:0];
                  sh_r    <= CW'(pos_w + 1'b1);
                  state_r <= S_SHIFT;
                end
              end
              OP_QUERY: begin
                if (kmin_w == '0) begin
                  st_r <= ST_EMPTY; state_r <= S_EMIT;
                end else begin
                  k_r     <= kmin_w[KW-1:0];
                  r_r     <= '0;
                  rd_i_r  <= '0;
                  found_r <= 1'b0;
                  state_r <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        S_SHIFT: begin
          pv_r <= more;
          if (more) begin
            if (ins_r) begin
              pwa_r <= sh_r[AW-1:0];
              sh_r  <= sh_r - 1'b1;
            end else begin
              pwa_r <= AW'(sh_r - 1'b1);
              sh_r  <= sh_r + 1'b1;
            end
          end else if (!pv_r) begin
            count_r <= ins_r ? count_r + 1'b1 : count_r - 1'b1;
            st_r    <= ST_OK;
            state_r <= S_EMIT;
          end
        end

        S_SCAN: begin
          v0_r   <= (rd_i_r < count_r);
          idx0_r <= rd_i_r[AW-1:0];
          if (rd_i_r < count_r) rd_i_r <= rd_i_r + 1'b1;
          v1_r   <= v0_r;
          idx1_r <= idx0_r;
          pt1_r  <= rdata_r;
          sqx_r  <= adx[15:0] * adx[15:0];
          sqy_r  <= ady[15:0] * ady[15:0];
          if (v1_r && !skip && (!found_r || d2 < best_d_r)) begin
            found_r   <= 1'b1;
            best_d_r  <= d2;
            best_i_r  <= idx1_r;
            best_pt_r <= pt1_r;
          end
          if (rd_i_r == count_r && !v0_r && !v1_r) begin
            st_r     <= ST_OK;
            opt_r    <= best_pt_r;
            od_r     <= best_d_r;
            last_r   <= (KW'(r_r + 1'b1) == k_r);
            prev_d_r <= best_d_r;
            prev_i_r <= best_i_r;
            state_r  <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (!out_stall) begin
            if (last_r) begin
              state_r <= S_IDLE;
            end else begin
              r_r     <= r_r + 1'b1;
              rd_i_r  <= '0;
              found_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_EMIT);
  assign out_status    = st_r;
  assign out_x         = opt_r[15:0];
  assign out_y         = opt_r[31:16];
  assign out_dist_sq   = od_r;
  assign out_count_now = cnt_out[10:0];
  assign out_last      = last_r;

endmodule
